// ===== design/fwms_pkg.sv =====
// Package with the shared widths, codes and controller/datapath signal groups.
package fwms_pkg;

  // Default tap count.
  localparam int TAPS_DEFAULT = 64;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 6;
  localparam int CODE_W   = 12;
  localparam int MODE_W   = 2;

  // Product of a 16-bit coefficient and a 12-bit history value.
  localparam int PROD_W = COEF_W + SAMPLE_W;
  // The sum wraps at 28 bits; its bits 27:16, plus a bias, form the output code.
  localparam int ACC_W     = PROD_W;
  localparam int OUT_SHIFT = 16;

  // Arithmetic constants.
  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 12'd2048;
  localparam logic [CODE_W-1:0]   OUT_BIAS      = 12'd1862;

  // Mode register codes; any other code acts as hold.
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD = 2'd2;

  // Input word kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hist_wr;
    logic coef_wr;
    logic start_mac;
    logic issue;
    logic take_mac;
    logic res_sample;
    logic res_last;
    logic out_load;
  } fwms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } fwms_stat_t;

endpackage

// ===== design/fwms_if.sv =====
// Valid/ready channel interfaces for the input and output words.
interface fwms_in_if import fwms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [SAMPLE_W-1:0]      sample;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;

  modport source (output valid, output func, output sample, output coef_index,
                  output coef_value, input ready);
  modport sink (input valid, input func, input sample, input coef_index,
                input coef_value, output ready);
endinterface

interface fwms_out_if import fwms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] dac_code;

  modport source (output valid, output dac_code, input ready);
  modport sink (input valid, input dac_code, output ready);
endinterface

// ===== design/fir_filter_with_mode_select_unit.sv =====
// Top level of the FIR filter with mode select: controller, datapath and checks.
//
//  Channel   Direction  Kind            Contents
//  din       in         valid/ready     func, sample, coef_index, coef_value
//  dout      out        valid/ready     dac_code
//  mode_*    in         write enable    2-bit mode register
//
// A coefficient word is written when accepted. A passthrough or hold sample sets the
// result word, which is then loaded into the output register. A filtered sample runs
// through the single multiply-accumulate pipeline, reading one tap per cycle from the
// two memories. The next word is accepted in the cycle after the result is loaded, even
// if the output word has not been taken. A result waits in place while dout is stalled.
// Reset clears the history valid bits at once; no clearing pass is needed.
module fir_filter_with_mode_select_unit import fwms_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mode_we,
  input  logic [MODE_W-1:0] mode_wdata,
  fwms_in_if.sink           din,
  fwms_out_if.source        dout
);

  fwms_cmd_t  cmd;
  fwms_stat_t stat;
  logic       in_ready;

  assign din.ready = in_ready;

  // Controller.
  fwms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (din.valid),
    .in_func    (din.func),
    .in_ready   (in_ready),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath.
  fwms_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample     (din.sample),
    .coef_index (din.coef_index),
    .coef_value (din.coef_value),
    .dout       (dout)
  );

  // An output word appears only after the controller loads a result.
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a result load");

  // A result is never loaded over a word that is still waiting.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!dout.valid || dout.ready))
    else $error("result loaded over a pending output word");

  // The sum is taken only once the MAC pipeline has drained.
  a_take_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.take_mac |-> stat.pipe_empty)
    else $error("filter sum taken while the pipeline is busy");

  // Tap issue stops after the last tap.
  a_issue_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && stat.last_issue) |=> !cmd.issue)
    else $error("tap issue ran past the last tap");

endmodule

// ===== design/fwms_ctrl.sv =====
// Controller state machine: input handshake, mode register and sequencing.
module fwms_ctrl import fwms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  logic              mode_we,
  input  logic [MODE_W-1:0] mode_wdata,
  input  fwms_stat_t        stat,
  output fwms_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [MODE_W-1:0] mode;
  logic              accept;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PASS;
    end else if (mode_we) begin
      mode <= mode_wdata;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.hist_wr = 1'b1;
            priority if (mode == MODE_PASS) begin
              cmd.res_sample = 1'b1;
              state_next     = S_FIN;
            end else if (mode == MODE_FIR) begin
              cmd.start_mac = 1'b1;
              state_next    = S_RUN;
            end else begin
              // Hold and the unused code both repeat the last word.
              cmd.res_last = 1'b1;
              state_next   = S_FIN;
            end
          end
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.take_mac = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/fwms_datapath.sv =====
// Datapath: history and coefficient memories, MAC pipeline and output register.
module fwms_datapath import fwms_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fwms_cmd_t                cmd,
  output fwms_stat_t               stat,
  input  logic [SAMPLE_W-1:0]      sample,
  input  logic [CIDX_W-1:0]        coef_index,
  input  logic signed [COEF_W-1:0] coef_value,
  fwms_out_if.source               dout
);

  localparam int PW = $clog2(TAPS);
  localparam int IW = (PW > CIDX_W) ? PW : CIDX_W;
  localparam logic [PW-1:0] LAST_TAP = PW'(TAPS - 1);

  logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
  logic signed [COEF_W-1:0]   coef_mem [TAPS];
  logic [TAPS-1:0]            hvalid;

  logic [PW-1:0]              ptr;
  logic [PW-1:0]              cnt;
  logic [PW-1:0]              raddr;
  logic [IW-1:0]              idx_ext;
  logic [PW-1:0]              coef_addr;
  logic                       coef_ok;

  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic                       hv_q;
  logic                       s1_v;
  logic signed [PROD_W-1:0]   prod;
  logic                       s2_v;
  logic [ACC_W-1:0]           acc;

  logic [CODE_W-1:0]          res;
  logic [CODE_W-1:0]          last_code;
  logic [CODE_W-1:0]          out_code;
  logic                       out_valid;

  // Coefficient write address; taps at or above the tap count are dropped.
  assign idx_ext   = IW'(coef_index);
  assign coef_addr = idx_ext[PW-1:0];
  assign coef_ok   = (int'(idx_ext) < TAPS);

  // History memory: new sample at the pointer, registered read during the MAC run.
  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      hist_mem[ptr] <= sample - SAMPLE_OFFSET;
    end
    if (cmd.issue) begin
      hist_q <= hist_mem[raddr];
    end
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && coef_ok) begin
      coef_mem[coef_addr] <= coef_value;
    end
    if (cmd.issue) begin
      coef_q <= coef_mem[cnt];
    end
  end

  // History valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (cmd.hist_wr) begin
      hvalid[ptr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      hv_q <= hvalid[raddr];
    end
  end

  // Tap counter and history address, walking newest to oldest.
  always_ff @(posedge clk) begin
    if (cmd.start_mac) begin
      cnt   <= '0;
      raddr <= ptr;
    end else if (cmd.issue) begin
      cnt   <= cnt + 1'b1;
      raddr <= (raddr == '0) ? LAST_TAP : raddr - 1'b1;
    end
  end

  // Pipeline stage flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (s1_v) begin
      if (hv_q) begin
        prod <= coef_q * hist_q;
      end else begin
        prod <= '0;
      end
    end
  end

  // Accumulate stage; the sum wraps.
  always_ff @(posedge clk) begin
    if (cmd.start_mac) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Write pointer advances only after a filtered sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.take_mac) begin
      ptr <= (ptr == LAST_TAP) ? '0 : ptr + 1'b1;
    end
  end

  // Result word for the current sample.
  always_ff @(posedge clk) begin
    if (cmd.res_sample) begin
      res <= sample;
    end else if (cmd.res_last) begin
      res <= last_code;
    end else if (cmd.take_mac) begin
      res <= acc[OUT_SHIFT +: CODE_W] + OUT_BIAS;
    end
  end

  // Last delivered code, repeated in hold mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code <= '0;
    end else if (cmd.out_load) begin
      last_code <= res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_code <= res;
    end
  end

  assign dout.valid    = out_valid;
  assign dout.dac_code = out_code;

  // Status to the controller.
  assign stat.last_issue = (cnt == LAST_TAP);
  assign stat.pipe_empty = !s1_v && !s2_v;
  assign stat.out_free   = !out_valid || dout.ready;

endmodule
